/* sv/hsm_pkg.sv */
package hsm_pkg;

    // Field widths of the stream items and the configuration register.
    localparam int X_W   = 6;
    localparam int Z_W   = 6;
    localparam int H_W   = 10;
    localparam int GW_W  = 7;
    localparam int CNT_OUT_W = 4;

    // Linear column index before wrapping: z * width + x stays below 2^13.
    localparam int IDX_W = Z_W + GW_W;

    // Defaults for the top-level parameters.
    localparam int COLUMNS_DEF      = 4096;
    localparam int MAX_SPANS_DEF    = 8;
    localparam int HEIGHT_CELLS_DEF = 1024;
    localparam logic [GW_W-1:0] GRID_WIDTH_RST = 7'd64;

    // One stored solid span, both ends inclusive.
    typedef struct packed {
        logic [H_W-1:0] top;
        logic [H_W-1:0] bottom;
    } span_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_STORED   = 2'd0,
        ST_FULL     = 2'd1,
        ST_REVERSED = 2'd2
    } status_t;

endpackage

/* sv/heightfield_span_merge.sv */
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata: col_x, col_z, span_bottom, span_top
// m_        out        m_tvalid/m_tready  m_tdata: merged_bottom, merged_top, span_count;
//                                          m_tuser: status
// cfg_      in         cfg_valid/cfg_ready cfg_data: grid_width
//
// One item at a time. The item is indexed, its row and count are read, and its column is
// scanned, one stored span scanned per cycle by the single compare unit (plus a step when
// the merged span lands below a stored span); it is then written back and offered. A
// reversed span is offered right after the row is read. If COLUMNS is not a power of two,
// the column index wrap adds S_MOD and S_SUB (reciprocal multiply, then subtract). s_tready
// rises at the edge that takes the result. After reset, the span count memory is cleared
// one column per cycle, with s_tready low. Configuration writes are taken in every cycle.
module heightfield_span_merge
    import hsm_pkg::*;
#(
    parameter int COLUMNS      = COLUMNS_DEF,
    parameter int MAX_SPANS    = MAX_SPANS_DEF,
    parameter int HEIGHT_CELLS = HEIGHT_CELLS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    // col_x [5:0], col_z [11:6], span_bottom [21:12], span_top [31:22]
    input  logic [31:0]     s_tdata,
    input  logic            s_tvalid,
    output logic            s_tready,
    // merged_bottom [9:0], merged_top [19:10], span_count [23:20]
    output logic [23:0]     m_tdata,
    // status [1:0]
    output logic [1:0]      m_tuser,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  logic [GW_W-1:0] cfg_data,
    input  logic            cfg_valid,
    output logic            cfg_ready
);

    localparam int CW       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CNT_W    = $clog2(MAX_SPANS + 1);
    localparam int SW       = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam bit COL_POW2 = (COLUMNS & (COLUMNS - 1)) == 0;
    // Reciprocal of COLUMNS, exact for every linear index below 2^IDX_W.
    localparam int     RSH_W   = IDX_W + CW;
    localparam longint RECIP   = ((longint'(1) << RSH_W) + COLUMNS - 1) / COLUMNS;
    localparam int     RECIP_W = IDX_W + 2;
    localparam int     PROD_W  = IDX_W + RECIP_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MOD, S_SUB, S_ADDR, S_LOAD, S_SCAN, S_WRITE, S_OUT
    } state_t;

    state_t                       state_reg;
    logic [CW:0]                  clr_reg;
    logic [GW_W-1:0]              gw_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [IDX_W-1:0]             q_reg;
    logic [CW-1:0]                rem_reg;
    logic [H_W-1:0]               s_reg;
    logic [H_W-1:0]               e_reg;
    logic [H_W-1:0]               nb_reg;
    logic [H_W-1:0]               nt_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             left_reg;
    logic [CNT_W-1:0]             oc_reg;
    logic                         done_reg;
    logic                         kany_reg;
    span_t [MAX_SPANS-1:0]        row_reg;
    span_t [MAX_SPANS-1:0]        out_reg;
    span_t [MAX_SPANS-1:0]        rowrd_reg;
    logic [CNT_W-1:0]             cntrd_reg;
    logic [H_W-1:0]               mb_reg;
    logic [H_W-1:0]               mt_reg;
    logic [CNT_OUT_W-1:0]         mc_reg;
    status_t                      mst_reg;
    logic                         mvalid_reg;

    // Row-wide span store and the per-column span counts.
    span_t [MAX_SPANS-1:0]        row_mem [COLUMNS];
    logic [CNT_W-1:0]             cnt_mem [COLUMNS];

    logic [X_W-1:0]               in_x;
    logic [Z_W-1:0]               in_z;
    logic [H_W-1:0]               in_b;
    logic [H_W-1:0]               in_t;
    logic [H_W-1:0]               in_b_cl;
    logic [H_W-1:0]               in_t_cl;
    logic [CW-1:0]                col_w;
    logic [PROD_W-1:0]            quot_prod;
    span_t                        head;
    span_t                        merged;
    span_t [MAX_SPANS-1:0]        row_shift;
    logic                         full;
    logic                         row_we;
    logic [CW-1:0]                cnt_waddr;
    logic [CNT_W-1:0]             cnt_wdata;
    logic                         cnt_we;

    // Input unpacking and height saturation.
    assign in_x = s_tdata[5:0];
    assign in_z = s_tdata[11:6];
    assign in_b = s_tdata[21:12];
    assign in_t = s_tdata[31:22];
    assign in_b_cl = (32'(in_b) >= HEIGHT_CELLS) ? H_W'(HEIGHT_CELLS - 1) : in_b;
    assign in_t_cl = (32'(in_t) >= HEIGHT_CELLS) ? H_W'(HEIGHT_CELLS - 1) : in_t;

    // Column address: a mask for power-of-two sizes, else the computed remainder.
    assign col_w = COL_POW2 ? CW'(32'(idx_reg) & (COLUMNS - 1)) : rem_reg;
    assign quot_prod = PROD_W'(idx_reg) * PROD_W'(RECIP);

    // Scan head, merged span and the rotated row.
    assign head   = row_reg[0];
    assign merged = '{top: nt_reg, bottom: nb_reg};
    always_comb begin
        for (int i = 0; i < MAX_SPANS; i++) begin
            row_shift[i] = (i + 1 < MAX_SPANS) ? row_reg[(i + 1) % MAX_SPANS] : row_reg[0];
        end
    end

    // A new span that overlaps nothing is dropped from a full column.
    assign full   = !kany_reg && (32'(cnt_reg) >= MAX_SPANS);
    assign row_we = (state_reg == S_WRITE) && !full;

    // Count memory write port: clearing pass or write-back.
    assign cnt_we    = (state_reg == S_CLEAR) || row_we;
    assign cnt_waddr = (state_reg == S_CLEAR) ? clr_reg[CW-1:0] : col_w;
    assign cnt_wdata = (state_reg == S_CLEAR) ? '0 : oc_reg;

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[col_w] <= out_reg;
        end
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (state_reg == S_ADDR) begin
            rowrd_reg <= row_mem[col_w];
            cntrd_reg <= cnt_mem[col_w];
        end
    end

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg <= GRID_WIDTH_RST;
        end else if (cfg_valid) begin
            gw_reg <= cfg_data;
        end
    end

    // Sequencer: clear, index, wrap, read, scan spans one per cycle, write back, offer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == COLUMNS - 1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        idx_reg <= IDX_W'(in_z) * IDX_W'(gw_reg) + IDX_W'(in_x);
                        s_reg   <= in_b_cl;
                        e_reg   <= in_t_cl;
                        rem_reg <= '0;
                        state_reg <= COL_POW2 ? S_ADDR : S_MOD;
                    end
                end
                S_MOD: begin
                    // Quotient of the wrap by multiplying with the reciprocal.
                    q_reg     <= IDX_W'(quot_prod >> RSH_W);
                    state_reg <= S_SUB;
                end
                S_SUB: begin
                    // Remainder is what the quotient leaves of the index.
                    rem_reg   <= CW'(32'(idx_reg) - 32'(q_reg) * COLUMNS);
                    state_reg <= S_ADDR;
                end
                S_ADDR: begin
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    row_reg  <= rowrd_reg;
                    cnt_reg  <= cntrd_reg;
                    left_reg <= cntrd_reg;
                    nb_reg   <= s_reg;
                    nt_reg   <= e_reg;
                    oc_reg   <= '0;
                    done_reg <= 1'b0;
                    kany_reg <= 1'b0;
                    if (s_reg > e_reg) begin
                        mb_reg     <= '0;
                        mt_reg     <= '0;
                        mc_reg     <= CNT_OUT_W'(cntrd_reg);
                        mst_reg    <= ST_REVERSED;
                        mvalid_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (left_reg == '0) begin
                        // Column exhausted: place the merged span if still pending.
                        if (!done_reg) begin
                            if (32'(oc_reg) < MAX_SPANS) begin
                                out_reg[oc_reg[SW-1:0]] <= merged;
                            end
                            oc_reg   <= oc_reg + 1'b1;
                            done_reg <= 1'b1;
                        end
                        state_reg <= S_WRITE;
                    end else if (head.top < s_reg) begin
                        // Span lies wholly below the new one.
                        out_reg[oc_reg[SW-1:0]] <= head;
                        oc_reg   <= oc_reg + 1'b1;
                        row_reg  <= row_shift;
                        left_reg <= left_reg - 1'b1;
                    end else if (!done_reg && head.bottom <= e_reg) begin
                        // Overlapping span is absorbed into the merged one.
                        if (head.bottom < nb_reg) begin
                            nb_reg <= head.bottom;
                        end
                        if (head.top > nt_reg) begin
                            nt_reg <= head.top;
                        end
                        kany_reg <= 1'b1;
                        row_reg  <= row_shift;
                        left_reg <= left_reg - 1'b1;
                    end else if (!done_reg) begin
                        // First span above: the merged span goes in ahead of it.
                        if (32'(oc_reg) < MAX_SPANS) begin
                            out_reg[oc_reg[SW-1:0]] <= merged;
                        end
                        oc_reg   <= oc_reg + 1'b1;
                        done_reg <= 1'b1;
                    end else begin
                        if (32'(oc_reg) < MAX_SPANS) begin
                            out_reg[oc_reg[SW-1:0]] <= head;
                        end
                        oc_reg   <= oc_reg + 1'b1;
                        row_reg  <= row_shift;
                        left_reg <= left_reg - 1'b1;
                    end
                end
                S_WRITE: begin
                    if (full) begin
                        mb_reg  <= '0;
                        mt_reg  <= '0;
                        mc_reg  <= CNT_OUT_W'(MAX_SPANS);
                        mst_reg <= ST_FULL;
                    end else begin
                        mb_reg  <= nb_reg;
                        mt_reg  <= nt_reg;
                        mc_reg  <= CNT_OUT_W'(oc_reg);
                        mst_reg <= ST_STORED;
                    end
                    mvalid_reg <= 1'b1;
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        mvalid_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {mc_reg, mt_reg, mb_reg};
    assign m_tuser  = mst_reg;

    // The input is never ready while a result is offered.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // An accepted result is not offered again in the next cycle.
    a_no_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result repeated");

    // A stored span is well ordered and leaves at least one span in its column.
    a_stored_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_STORED) |->
            (m_tdata[9:0] <= m_tdata[19:10]) && (m_tdata[23:20] != '0))
        else $error("stored result malformed");

    // An accepted item is not followed by another in the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item taken while busy");

endmodule

/* dv/heightfield_span_merge_test.sv */
module heightfield_span_merge_test;
    import hsm_pkg::*;

    localparam int COLS           = COLUMNS_DEF;
    localparam int SPANS_PER_COL  = MAX_SPANS_DEF;
    localparam int CELLS          = HEIGHT_CELLS_DEF;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 180;
    localparam int DIRECTED_ROWS  = 21;
    // Extra wait after the result queue drains, meant to cover any straggler.
    localparam int MERGE_LATENCY  = 16;
    // The count memory clear after reset holds s_tready low.
    localparam int WATCHDOG_LIMIT = 4 * COLS + 20000;

    // One result item as the block reports it.
    typedef struct packed {
        logic [H_W-1:0]       bottom;
        logic [H_W-1:0]       top;
        logic [CNT_OUT_W-1:0] count;
        status_t              status;
    } span_result_t;

    // One row of the directed table; a typed expectation replaces the predicted one.
    typedef struct {
        int           x;
        int           z;
        int           bottom;
        int           top;
        bit           typed;
        span_result_t res;
    } span_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic [31:0]          s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [GW_W-1:0]      cfg_data;
    logic                 cfg_valid;
    logic                 cfg_ready;

    // Shadow copy of the column store and the width register.
    logic [H_W-1:0]       model_bottoms [0:COLS-1][0:SPANS_PER_COL-1];
    logic [H_W-1:0]       model_tops    [0:COLS-1][0:SPANS_PER_COL-1];
    int                   model_counts  [0:COLS-1];
    int                   model_width;

    span_result_t         expected_spans [$];
    int                   mismatch_count;
    int                   idle_cycles = 0;
    bit                   calm_tail;
    int                   hot_x [4];
    int                   hot_z [4];

    // Column (0,0) exercises the extremes, column (63,63) fills up and merges.
    span_row_t directed_rows [DIRECTED_ROWS] = '{
        '{5,  0,  10,   9,    1'b1, '{10'd0,    10'd0,    4'd0, ST_REVERSED}},
        '{0,  0,  0,    0,    1'b1, '{10'd0,    10'd0,    4'd1, ST_STORED}},
        '{0,  0,  1023, 1023, 1'b1, '{10'd1023, 10'd1023, 4'd2, ST_STORED}},
        '{0,  0,  0,    1023, 1'b1, '{10'd0,    10'd1023, 4'd1, ST_STORED}},
        '{63, 63, 10,   19,   1'b0, '0},
        '{63, 63, 20,   29,   1'b0, '0},
        '{63, 63, 40,   41,   1'b0, '0},
        '{63, 63, 50,   51,   1'b0, '0},
        '{63, 63, 60,   61,   1'b0, '0},
        '{63, 63, 70,   71,   1'b0, '0},
        '{63, 63, 80,   81,   1'b0, '0},
        '{63, 63, 90,   91,   1'b0, '0},
        '{63, 63, 100,  101,  1'b1, '{10'd0,    10'd0,    4'd8, ST_FULL}},
        '{63, 63, 45,   55,   1'b0, '0},
        '{63, 63, 1,    2,    1'b1, '{10'd0,    10'd0,    4'd8, ST_FULL}},
        '{63, 63, 600,  500,  1'b1, '{10'd0,    10'd0,    4'd8, ST_REVERSED}},
        '{63, 63, 15,   65,   1'b0, '0},
        '{63, 63, 21,   22,   1'b0, '0},
        '{63, 0,  1023, 1023, 1'b0, '0},
        '{0,  63, 512,  1023, 1'b0, '0},
        '{42, 21, 1023, 0,    1'b1, '{10'd0,    10'd0,    4'd0, ST_REVERSED}}
    };

    heightfield_span_merge #(
        .COLUMNS      (COLS),
        .MAX_SPANS    (SPANS_PER_COL),
        .HEIGHT_CELLS (CELLS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int clamp_cell(input int v);
        if (v >= CELLS)
            return CELLS - 1;
        return v;
    endfunction

    // Merges one span into the shadow store and returns the result it causes.
    task automatic merge_span_model(input int x, input int z, input int b_in, input int t_in,
                                    output span_result_t res);
        int s;
        int e;
        int col;
        int count;
        int lo;
        int hi;
        int n;
        int nb;
        int nt;
        int i;
        int tb [SPANS_PER_COL];
        int tt [SPANS_PER_COL];
        s     = clamp_cell(b_in);
        e     = clamp_cell(t_in);
        col   = (z * model_width + x) % COLS;
        count = model_counts[col];
        if (count > SPANS_PER_COL)
            count = SPANS_PER_COL;
        res = '0;
        if (s > e) begin
            res.count  = count[CNT_OUT_W-1:0];
            res.status = ST_REVERSED;
            return;
        end
        // Find the run of stored spans that share a cell with [s, e].
        lo = 0;
        while (lo < count && model_tops[col][lo] < s)
            lo++;
        hi = lo;
        while (hi < count && model_bottoms[col][hi] <= e)
            hi++;
        if (hi == lo && count >= SPANS_PER_COL) begin
            res.count  = CNT_OUT_W'(SPANS_PER_COL);
            res.status = ST_FULL;
            return;
        end
        nb = s;
        nt = e;
        if (hi > lo) begin
            if (model_bottoms[col][lo] < nb)
                nb = int'(model_bottoms[col][lo]);
            if (model_tops[col][hi-1] > nt)
                nt = int'(model_tops[col][hi-1]);
        end
        // Rebuild the column: spans below, the merged span, spans above.
        n = 0;
        for (i = 0; i < lo; i++) begin
            tb[n] = int'(model_bottoms[col][i]);
            tt[n] = int'(model_tops[col][i]);
            n++;
        end
        tb[n] = nb;
        tt[n] = nt;
        n++;
        for (i = hi; i < count && n < SPANS_PER_COL; i++) begin
            tb[n] = int'(model_bottoms[col][i]);
            tt[n] = int'(model_tops[col][i]);
            n++;
        end
        for (i = 0; i < n; i++) begin
            model_bottoms[col][i] = tb[i][H_W-1:0];
            model_tops[col][i]    = tt[i][H_W-1:0];
        end
        model_counts[col] = n;
        res.bottom = nb[H_W-1:0];
        res.top    = nt[H_W-1:0];
        res.count  = n[CNT_OUT_W-1:0];
        res.status = ST_STORED;
    endtask

    // Offers one span item, waits for it to be taken and records its expected result.
    task automatic send_span(input int x, input int z, input int b, input int t,
                             input bit typed, input span_result_t typed_res);
        span_result_t pred;
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t[H_W-1:0], b[H_W-1:0], z[Z_W-1:0], x[X_W-1:0]};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        merge_span_model(x, z, b, t, pred);
        expected_spans.push_back(typed ? typed_res : pred);
    endtask

    // Writes the width register once the block has drained.
    task automatic set_grid_width(input int w);
        s_tvalid <= 1'b0;
        while (expected_spans.size() != 0)
            @(posedge aclk);
        repeat (MERGE_LATENCY) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= w[GW_W-1:0];
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid   <= 1'b0;
        model_width = w;
    endtask

    // Builds one random item, mostly short spans aimed at a few busy columns.
    task automatic random_span(output int x, output int z, output int b, output int t);
        int mode;
        int pick;
        int len;
        mode = $urandom_range(0, 99);
        pick = $urandom_range(0, 3);
        x    = hot_x[pick];
        z    = hot_z[pick];
        b    = $urandom_range(0, CELLS - 1);
        if (mode < 70) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 20);
            t   = (b + len > CELLS - 1) ? CELLS - 1 : b + len;
        end else if (mode < 85) begin
            x = $urandom_range(0, 63);
            z = $urandom_range(0, 63);
            t = $urandom_range(b, CELLS - 1);
        end else if (mode < 93) begin
            b = $urandom_range(1, CELLS - 1);
            t = $urandom_range(0, b - 1);
        end else begin
            x = $urandom_range(0, 63);
            z = $urandom_range(0, 63);
            t = $urandom_range(0, CELLS - 1);
        end
    endtask

    // Main sequence: reset, directed table, then random phases at several widths.
    initial begin
        int widths [PHASES];
        int x;
        int z;
        int b;
        int t;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        calm_tail      = 1'b0;
        mismatch_count = 0;
        model_width    = int'(GRID_WIDTH_RST);
        for (int c = 0; c < COLS; c++)
            model_counts[c] = 0;
        widths = '{1, 127, 0, $urandom_range(2, 126), 64, 20};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r])
            send_span(directed_rows[r].x, directed_rows[r].z, directed_rows[r].bottom,
                      directed_rows[r].top, directed_rows[r].typed, directed_rows[r].res);

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1)
                calm_tail = 1'b1;
            set_grid_width(widths[p]);
            for (int h = 0; h < 4; h++) begin
                hot_x[h] = $urandom_range(0, 63);
                hot_z[h] = $urandom_range(0, 63);
            end
            repeat (PHASE_ITEMS) begin
                random_span(x, z, b, t);
                send_span(x, z, b, t, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (expected_spans.size() != 0)
            @(posedge aclk);
        repeat (2 * MERGE_LATENCY) @(posedge aclk);
        if (expected_spans.size() != 0) begin
            $error("%0d expected results never arrived", expected_spans.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Result side readiness: random stall bursts, always ready in the tail.
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!calm_tail && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Compare each accepted result item with the oldest expectation.
    always @(posedge aclk) begin
        span_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_spans.size() == 0) begin
                $error("result item with no expectation: tdata %h tuser %h", m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = expected_spans.pop_front();
                if (m_tdata[9:0] !== want.bottom) begin
                    $error("merged_bottom: expected %0d, actual %0d", want.bottom, m_tdata[9:0]);
                    mismatch_count++;
                end
                if (m_tdata[19:10] !== want.top) begin
                    $error("merged_top: expected %0d, actual %0d", want.top, m_tdata[19:10]);
                    mismatch_count++;
                end
                if (m_tdata[23:20] !== want.count) begin
                    $error("span_count: expected %0d, actual %0d", want.count, m_tdata[23:20]);
                    mismatch_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no channel has moved an item for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
